### rtl/bitmap_contiguous_page_allocator_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the contiguous page allocator
// Shared concurrent assertion shapes, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_CONTIGUOUS_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_CONTIGUOUS_PAGE_ALLOCATOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCPA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BCPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/bcpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpa_pkg
// Field layout, command and status codes of the contiguous page allocator.
// ----------------------------------------------------------------------------
package bcpa_pkg;

	localparam int CMD_W    = 1;
	localparam int START_W  = 12;
	localparam int COUNT_W  = 13;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 12;

	// request tdata: start_page at bit 0, page_count above it
	localparam int START_LSB = 0;
	localparam int COUNT_LSB = START_W;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 16;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam cmd_t CMD_ALLOC = 1'b0;
	localparam cmd_t CMD_FREE  = 1'b1;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NO_SPACE  = 2'd1;
	localparam status_t ST_BAD_RANGE = 2'd2;

endpackage

### rtl/bitmap_contiguous_page_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_contiguous_page_allocator_core
// First-fit allocator of contiguous page runs over a used-page bitmap held
// in one word-wide RAM; also frees runs by clearing their bits.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata (low bit up)              tuser
//  s_axis    in   start_page[11:0], page_count    command (0 alloc, 1 free)
//                 [24:12], zero pad to 32
//  m_axis    out  page_index[11:0], zero pad      status (0 ok, 1 no_space,
//                 to 16                           2 bad_range)
//
//  Reset sweeps the bitmap RAM to zero word by word, s_axis_tready low.
//  Allocate: one read per scanned word through the scan pipeline, setup,
//  one read-modify-write per touched word; no fit ends after the scan.
//  Free: setup and per-word read-modify-write; rejected requests skip both.
//  One request is in work at a time; a finished one holds until the result
//  register is free, so a waiting result stalls the next request only.
// ----------------------------------------------------------------------------
module bitmap_contiguous_page_allocator_core #(
	parameter int PAGE_SLOTS = 4096,
	parameter int WORD_BITS  = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// start_page[11:0], page_count[24:12], zero pad
	input  logic [bcpa_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// command
	input  logic [bcpa_pkg::CMD_W-1:0]       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// page_index[11:0], zero pad
	output logic [bcpa_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	// status
	output logic [bcpa_pkg::STATUS_W-1:0]    m_axis_tuser
);

	localparam int MAP_WORDS = PAGE_SLOTS / WORD_BITS;
	localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int LW = $clog2(WORD_BITS);
	localparam int NW = LW + 1;
	localparam int PW = $clog2(PAGE_SLOTS);
	localparam int CW = PW + 1;
	localparam int XW = ((CW > bcpa_pkg::COUNT_W) ? CW : bcpa_pkg::COUNT_W) + 1;

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_SETUP = 3'd3;
	localparam logic [2:0] S_MARK  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	// control
	logic [2:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [AW:0]   scan_w_q;
	logic          vld_s1;
	logic          vld_s2;
	logic [AW-1:0] mk_w_q;
	logic          mk_busy_q;
	logic          mk_vld_s1;
	logic          out_valid_q;

	// payload
	bcpa_pkg::cmd_t    cmd_q;
	logic [CW-1:0]     len_q;
	logic [PW-1:0]     first_q;
	logic [CW-1:0]     carry_q;
	logic [PW-1:0]     begin_q;
	logic [AW-1:0]     idx_s1;
	logic [AW-1:0]     idx_s2;
	logic [WORD_BITS-1:0] win_s2;
	logic [NW-1:0]     tz_s2;
	logic [NW-1:0]     lz_s2;
	logic              all_s2;
	logic [AW-1:0]     fw_q;
	logic [AW-1:0]     lastw_q;
	logic [LW-1:0]     lo_q;
	logic [NW-1:0]     hi_q;
	logic [WORD_BITS-1:0] mask_s1;
	logic [AW-1:0]     mk_addr_s1;
	logic              mk_last_s1;
	bcpa_pkg::status_t res_status_q;
	logic [bcpa_pkg::INDEX_W-1:0] res_index_q;
	bcpa_pkg::status_t out_status_q;
	logic [bcpa_pkg::INDEX_W-1:0] out_index_q;

	// RAM ports
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	bcpa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_bitmap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ------------------------------------------------------------------
	// request decode
	// ------------------------------------------------------------------
	logic          in_acc;
	logic [XW-1:0] in_len;
	logic [XW-1:0] in_first;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign in_len = XW'(s_axis_tdata[bcpa_pkg::COUNT_LSB +: bcpa_pkg::COUNT_W]);
	assign in_first = XW'(s_axis_tdata[bcpa_pkg::START_LSB +: bcpa_pkg::START_W]);

	// ------------------------------------------------------------------
	// scan, stage 1: per-word window mask, trailing and leading free counts
	// ------------------------------------------------------------------
	logic                 scan_rd;
	logic [NW-1:0]        win_n;
	logic                 win_small;
	logic [WORD_BITS-1:0] free_w;
	logic [WORD_BITS-1:0] pw [NW];
	logic [WORD_BITS-1:0] win_c;
	logic [NW-1:0]        tz_c;
	logic [NW-1:0]        lz_c;

	assign scan_rd   = (state_q == S_SCAN) && (scan_w_q < (AW + 1)'(MAP_WORDS));
	assign win_n     = len_q[NW-1:0];
	assign win_small = (len_q <= CW'(WORD_BITS));
	assign free_w    = ~ram_rdata;

	always_comb begin
		// pw[j] bit x: pages x .. x + 2^j - 1 of this word are all free
		pw[0] = free_w;
		for (int j = 0; j < LW; j++) begin
			pw[j+1] = pw[j] & (pw[j] >> (1 << j));
		end
		// combine powers of two into a window of win_n pages
		win_c = '1;
		for (int j = 0; j < NW; j++) begin
			if (win_n[j]) begin
				win_c = win_c & (pw[j] >> (win_n & NW'((1 << j) - 1)));
			end
		end
		if (!win_small) begin
			win_c = '0;
		end
	end

	always_comb begin
		tz_c = NW'(WORD_BITS);
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (ram_rdata[i]) begin
				tz_c = NW'(i);
			end
		end
		lz_c = NW'(WORD_BITS);
		for (int i = 0; i < WORD_BITS; i++) begin
			if (ram_rdata[i]) begin
				lz_c = NW'(WORD_BITS - 1 - i);
			end
		end
	end

	// ------------------------------------------------------------------
	// scan, stage 2: first fit decision and run carry across words
	// ------------------------------------------------------------------
	logic [LW-1:0] pos_c;
	logic          win_any;
	logic [CW:0]   cross_sum;
	logic          cross_hit;
	logic [PW-1:0] base2;
	logic          scan_live;
	logic          found_now;
	logic          last_now;
	logic [PW-1:0] found_start;

	always_comb begin
		pos_c = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (win_s2[i]) begin
				pos_c = LW'(i);
			end
		end
	end

	assign win_any     = |win_s2;
	assign cross_sum   = (CW + 1)'(carry_q) + (CW + 1)'(tz_s2);
	assign cross_hit   = (carry_q != '0) && (cross_sum >= (CW + 1)'(len_q));
	assign base2       = PW'(idx_s2) << LW;
	assign scan_live   = vld_s2 && (state_q == S_SCAN);
	assign found_now   = scan_live && (cross_hit || win_any);
	assign last_now    = scan_live && !found_now && (idx_s2 == AW'(MAP_WORDS - 1));
	// a run carried in from lower words always starts before one inside this word
	assign found_start = cross_hit ? begin_q : (base2 | PW'(pos_c));

	// ------------------------------------------------------------------
	// mark / clear: per-word mask and read-modify-write
	// ------------------------------------------------------------------
	logic [CW-1:0]        end_c;
	logic [AW-1:0]        lastw_c;
	logic                 mk_rd;
	logic [WORD_BITS-1:0] lo_m;
	logic [WORD_BITS:0]   hi_full;
	logic [WORD_BITS-1:0] hi_m;

	assign end_c   = CW'(first_q) + len_q;
	assign lastw_c = AW'((end_c - CW'(1)) >> LW);
	assign mk_rd   = (state_q == S_MARK) && mk_busy_q;
	assign lo_m    = (mk_w_q == fw_q) ? ({WORD_BITS{1'b1}} << lo_q) : '1;
	assign hi_full = ((WORD_BITS + 1)'(1) << hi_q) - (WORD_BITS + 1)'(1);
	assign hi_m    = (mk_w_q == lastw_q) ? hi_full[WORD_BITS-1:0] : '1;

	always_comb begin
		ram_re    = scan_rd || mk_rd;
		ram_raddr = (state_q == S_MARK) ? mk_w_q : scan_w_q[AW-1:0];
		if (state_q == S_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = mk_vld_s1;
			ram_waddr = mk_addr_s1;
			// set on allocate, clear on free
			ram_wdata = (cmd_q == bcpa_pkg::CMD_ALLOC) ? (ram_rdata | mask_s1)
				: (ram_rdata & ~mask_s1);
		end
	end

	// ------------------------------------------------------------------
	// control state
	// ------------------------------------------------------------------
	logic out_load;

	assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			scan_w_q    <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			mk_w_q      <= '0;
			mk_busy_q   <= 1'b0;
			mk_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1    <= scan_rd;
			vld_s2    <= vld_s1;
			mk_vld_s1 <= mk_rd;
			if (scan_rd) begin
				scan_w_q <= scan_w_q + (AW + 1)'(1);
			end
			if (mk_rd) begin
				mk_w_q <= mk_w_q + AW'(1);
				if (mk_w_q == lastw_q) begin
					mk_busy_q <= 1'b0;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAP_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						if (s_axis_tuser == bcpa_pkg::CMD_ALLOC) begin
							if (in_len == '0 || in_len > XW'(PAGE_SLOTS)) begin
								state_q <= S_DONE;
							end else begin
								scan_w_q <= '0;
								state_q  <= S_SCAN;
							end
						end else begin
							if (in_first + in_len > XW'(PAGE_SLOTS) || in_len == '0) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_SETUP;
							end
						end
					end
				end
				S_SCAN: begin
					if (found_now) begin
						state_q <= S_SETUP;
					end else if (last_now) begin
						state_q <= S_DONE;
					end
				end
				S_SETUP: begin
					mk_w_q    <= AW'(first_q >> LW);
					mk_busy_q <= 1'b1;
					state_q   <= S_MARK;
				end
				S_MARK: begin
					if (mk_vld_s1 && mk_last_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		idx_s1 <= scan_w_q[AW-1:0];
		idx_s2 <= idx_s1;
		win_s2 <= win_c;
		tz_s2  <= tz_c;
		lz_s2  <= lz_c;
		all_s2 <= (ram_rdata == '0);

		mask_s1    <= lo_m & hi_m;
		mk_addr_s1 <= mk_w_q;
		mk_last_s1 <= (mk_w_q == lastw_q);

		if (in_acc) begin
			cmd_q        <= s_axis_tuser;
			len_q        <= in_len[CW-1:0];
			first_q      <= in_first[PW-1:0];
			carry_q      <= '0;
			begin_q      <= '0;
			res_index_q  <= '0;
			if (s_axis_tuser == bcpa_pkg::CMD_ALLOC) begin
				res_status_q <= bcpa_pkg::ST_NO_SPACE;
			end else if (in_first + in_len > XW'(PAGE_SLOTS)) begin
				res_status_q <= bcpa_pkg::ST_BAD_RANGE;
			end else begin
				res_status_q <= bcpa_pkg::ST_OK;
			end
		end

		// carry a free run into the next word, or hold the winning start
		if (found_now) begin
			first_q <= found_start;
		end else if (scan_live) begin
			if (all_s2) begin
				carry_q <= carry_q + CW'(WORD_BITS);
				if (carry_q == '0) begin
					begin_q <= base2;
				end
			end else begin
				carry_q <= CW'(lz_s2);
				begin_q <= PW'((PW + 1)'(base2) + (PW + 1)'(WORD_BITS) - (PW + 1)'(lz_s2));
			end
		end

		if (state_q == S_SETUP) begin
			fw_q         <= AW'(first_q >> LW);
			lastw_q      <= lastw_c;
			lo_q         <= first_q[LW-1:0];
			hi_q         <= NW'(end_c - (CW'(lastw_c) << LW));
			res_status_q <= bcpa_pkg::ST_OK;
			res_index_q  <= (cmd_q == bcpa_pkg::CMD_ALLOC)
				? bcpa_pkg::INDEX_W'(first_q) : '0;
		end

		if (out_load) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = bcpa_pkg::M_TDATA_W'(out_index_q);
	assign m_axis_tuser  = out_status_q;

endmodule

### rtl/bcpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpa_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bcpa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/bcpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpa_checker
// Port-level checks on request/result ordering and result encoding.
// ----------------------------------------------------------------------------
`include "bitmap_contiguous_page_allocator_core_macros.svh"

module bcpa_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [bcpa_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	input logic [bcpa_pkg::CMD_W-1:0]       s_axis_tuser,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [bcpa_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	input logic [bcpa_pkg::STATUS_W-1:0]    m_axis_tuser
);

	logic       in_acc;
	logic       out_acc;
	logic [1:0] pend_q;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	`BCPA_ASSERT_NOW(a_no_unrequested_result, out_acc, pend_q != 2'd0, "result without a request")
	`BCPA_ASSERT_NOW(a_one_in_work, pend_q == 2'd2, !s_axis_tready, "request taken while full")
	`BCPA_ASSERT_NOW(a_status_code, m_axis_tvalid, m_axis_tuser == bcpa_pkg::ST_OK || m_axis_tuser == bcpa_pkg::ST_NO_SPACE || m_axis_tuser == bcpa_pkg::ST_BAD_RANGE, "bad status code")
	`BCPA_ASSERT_NOW(a_zero_index_on_error, m_axis_tvalid && m_axis_tuser != bcpa_pkg::ST_OK, m_axis_tdata == '0, "nonzero index on failed request")
	`BCPA_ASSERT_NEXT(a_result_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind bitmap_contiguous_page_allocator_core bcpa_checker u_bcpa_checker (.*);

### tb/page_allocator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_allocator_checker
// Watches both stream channels of the page allocator, keeps a shadow bitmap,
// predicts each response at request time and compares responses in order.
// ----------------------------------------------------------------------------
module page_allocator_checker #(
	parameter int PAGE_SLOTS = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [bcpa_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input  logic [bcpa_pkg::CMD_W-1:0]     s_axis_tuser,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [bcpa_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input  logic [bcpa_pkg::STATUS_W-1:0]  m_axis_tuser,
	output int unsigned                    mismatches,
	output int unsigned                    outstanding
);

	import bcpa_pkg::*;

	typedef struct packed {
		status_t                status;
		logic [INDEX_W-1:0]     page_index;
	} page_response_t;

	logic [PAGE_SLOTS-1:0] shadow_used;
	page_response_t        awaited_responses[$];

	// First fit over the shadow bitmap on allocate, plain clear on free.
	function automatic page_response_t serve_request(input cmd_t cmd,
			input logic [START_W-1:0] first, input logic [COUNT_W-1:0] len);
		page_response_t res;
		int run;
		int run_start;
		int found;
		res.status = ST_OK;
		res.page_index = '0;
		if (cmd == CMD_ALLOC) begin
			found = -1;
			run = 0;
			run_start = 0;
			if (len != 0 && len <= PAGE_SLOTS) begin
				for (int p = 0; p < PAGE_SLOTS && found < 0; p++) begin
					if (shadow_used[p]) begin
						run = 0;
					end else begin
						if (run == 0)
							run_start = p;
						run++;
						if (run == len)
							found = run_start;
					end
				end
			end
			if (found < 0) begin
				res.status = ST_NO_SPACE;
			end else begin
				for (int p = found; p < found + int'(len); p++)
					shadow_used[p] = 1'b1;
				res.page_index = found[INDEX_W-1:0];
			end
		end else if (int'(first) + int'(len) > PAGE_SLOTS) begin
			res.status = ST_BAD_RANGE;
		end else begin
			for (int p = int'(first); p < int'(first) + int'(len); p++)
				shadow_used[p] = 1'b0;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		page_response_t want;
		page_response_t got;
		int unsigned    n_bad;
		n_bad = 0;
		if (!arst_n) begin
			shadow_used = '0;
			awaited_responses.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			// A response never belongs to the request accepted on the same edge.
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = m_axis_tuser;
				got.page_index = m_axis_tdata[INDEX_W-1:0];
				if (awaited_responses.size() == 0) begin
					$display("%0t: unexpected response, expected none, got status %0d index %0d",
						$time, got.status, got.page_index);
					n_bad++;
				end else begin
					want = awaited_responses.pop_front();
					if (got.status !== want.status) begin
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, want.status, got.status);
						n_bad++;
					end
					if (got.page_index !== want.page_index) begin
						$display("%0t: page_index mismatch, expected %0d, got %0d",
							$time, want.page_index, got.page_index);
						n_bad++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				awaited_responses.push_back(serve_request(s_axis_tuser,
					s_axis_tdata[START_LSB +: START_W], s_axis_tdata[COUNT_LSB +: COUNT_W]));
			mismatches <= mismatches + n_bad;
			outstanding <= awaited_responses.size();
		end
	end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives allocate and free requests into the contiguous page allocator with
// random gaps and response stalls; a side checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;

	import bcpa_pkg::*;

	localparam int PAGE_SLOTS   = 4096;
	localparam int RANDOM_ITEMS = 1450;
	// room after the drain for a stray response
	localparam int DRAIN_CYCLES = 300;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// start_page[11:0], page_count[24:12], zero pad
	logic [S_TDATA_W-1:0]  s_axis_tdata;
	// command
	logic [CMD_W-1:0]      s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// page_index[11:0], zero pad
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	// status
	logic [STATUS_W-1:0]   m_axis_tuser;

	int unsigned mismatches;
	int unsigned outstanding;
	bit          tx_burst;

	bitmap_contiguous_page_allocator_core #(
		.PAGE_SLOTS(PAGE_SLOTS),
		.WORD_BITS (64)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	page_allocator_checker #(
		.PAGE_SLOTS(PAGE_SLOTS)
	) alloc_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Idle length: zero with the given chance, else mostly short, a few long.
	function automatic int idle_len(input int zero_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < zero_pct)
			return 0;
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(12, 60);
	endfunction

	// Allocation sizes: mostly small runs, some medium, rare huge, zero
	// and oversize requests.
	function automatic int alloc_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return 0;
		if (r < 6)
			return $urandom_range(PAGE_SLOTS + 1, 8191);
		if (r < 9)
			return $urandom_range(1000, PAGE_SLOTS);
		if (r < 25)
			return $urandom_range(33, 300);
		return $urandom_range(1, 32);
	endfunction

	// Present one request, hold it until the handshake, then idle a while.
	// With no gap, tvalid simply stays high for the next request.
	task automatic issue(input cmd_t cmd, input int first, input int count);
		logic [S_TDATA_W-1:0] word;
		int                   gap;
		word = '0;
		word[START_LSB +: START_W] = first[START_W-1:0];
		word[COUNT_LSB +: COUNT_W] = count[COUNT_W-1:0];
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		s_axis_tuser <= cmd;
		do
			@(posedge clk);
		while (!s_axis_tready);
		gap = idle_len(tx_burst ? 100 : 55);
		if (gap > 0) begin
			// drop valid and scramble the bus so idle data is never trusted
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= $urandom;
			s_axis_tuser <= cmd_t'($urandom_range(0, 1));
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic issue_alloc(input int count);
		// start_page is ignored on allocate; fill it with noise anyway
		issue(CMD_ALLOC, $urandom_range(0, PAGE_SLOTS - 1), count);
	endtask

	// Hold off the sender until every pending response has come back.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Response side: random stalls, with calm stretches of no stalls at all.
	initial begin
		int stall_left;
		int calm_left;
		bit calm;
		stall_left = 0;
		calm_left = 0;
		calm = 1'b0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (calm_left == 0) begin
				calm = ($urandom_range(0, 3) == 0);
				calm_left = $urandom_range(100, 800);
			end
			calm_left--;
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (calm || $urandom_range(0, 99) < 65) begin
				m_axis_tready <= 1'b1;
			end else begin
				stall_left = idle_len(0) - 1;
				m_axis_tready <= 1'b0;
			end
		end
	end

	// Generous bound on the whole run.
	initial begin
		#8_000_000;
		$display("tb: errors");
		$finish;
	end

	initial begin
		int  phase_left;
		bit  fill_phase;
		int  r;
		int  first;
		phase_left = 0;
		fill_phase = 1'b0;
		tx_burst = 1'b0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= CMD_ALLOC;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero, oversize and all-ones allocate counts.
		issue_alloc(0);
		issue_alloc(8191);
		issue_alloc(PAGE_SLOTS + 1);
		// pack word 0, then a full word from 64
		issue_alloc(1);
		issue_alloc(63);
		issue_alloc(64);
		// free already-free last page, then past the end, a zero count, far past the end
		issue(CMD_FREE, PAGE_SLOTS - 1, 1);
		issue(CMD_FREE, PAGE_SLOTS - 1, 2);
		issue(CMD_FREE, 0, 0);
		issue(CMD_FREE, PAGE_SLOTS - 1, 8191);
		// punch a hole, refill part of it, skip it when too small
		issue(CMD_FREE, 1, 10);
		issue_alloc(5);
		issue_alloc(20);
		// range ending exactly at the top, then one page over
		issue(CMD_FREE, 4000, 96);
		issue(CMD_FREE, 4000, 97);
		// whole store: clear, fill, overflow, reopen and refill the last page, clear
		issue(CMD_FREE, 0, PAGE_SLOTS);
		issue_alloc(PAGE_SLOTS);
		issue_alloc(1);
		issue(CMD_FREE, PAGE_SLOTS - 1, 1);
		issue_alloc(1);
		issue(CMD_FREE, 0, PAGE_SLOTS);

		wait_drained();

		// Random: alternate fill-heavy and drain-heavy phases so the map
		// fragments, fills up and empties again.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (phase_left == 0) begin
				fill_phase = !fill_phase;
				phase_left = $urandom_range(40, 160);
				tx_burst = ($urandom_range(0, 3) == 0);
			end
			phase_left--;
			if (i == RANDOM_ITEMS / 2)
				wait_drained();
			if ($urandom_range(0, 99) < (fill_phase ? 75 : 35)) begin
				issue_alloc(alloc_count());
			end else begin
				r = $urandom_range(0, 99);
				// used pages cluster low under first fit; aim most frees there
				first = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 1023)
					: $urandom_range(0, PAGE_SLOTS - 1);
				if (r < 8)
					issue(CMD_FREE, $urandom_range(3900, PAGE_SLOTS - 1),
						$urandom_range(0, 400));
				else if (r < 10)
					issue(CMD_FREE, 0, PAGE_SLOTS);
				else if (r < 12)
					issue(CMD_FREE, first, $urandom_range(0, 8191));
				else if (r < 25)
					issue(CMD_FREE, first, $urandom_range(65, 600));
				else
					issue(CMD_FREE, first, $urandom_range(1, 64));
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
